// ----- rtl/core/rllc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllc_pkg
// Shared types and constants for the run-length limit checker core.
// ----------------------------------------------------------------------------
package rllc_pkg;

	localparam int POSITION_BITS  = 24;
	localparam int RUN_LIMIT_BITS = 16;
	localparam int RUN_BITS       = RUN_LIMIT_BITS + 1;
	localparam int CFG_DATA_BITS  = POSITION_BITS;
	localparam int CFG_INDEX_BITS = 2;

	typedef logic [POSITION_BITS-1:0]  pos_t;
	typedef logic [RUN_LIMIT_BITS-1:0] limit_t;
	typedef logic [RUN_BITS-1:0]       run_t;

	// register indexes on the configuration port
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_MAX_ZERO_RUN = 2'd0,
		CFG_MAX_ONE_RUN  = 2'd1,
		CFG_COUNT_MODE   = 2'd2,
		CFG_START_OFFSET = 2'd3
	} cfg_index_t;

	// history of the previous bit in a scan
	typedef enum logic [1:0] {
		PREV_ZERO = 2'd0,
		PREV_ONE  = 2'd1,
		PREV_NONE = 2'd2
	} prev_bit_t;

	typedef struct packed {
		limit_t max_zero_run;
		limit_t max_one_run;
		logic   count_mode;
		pos_t   start_offset;
	} rllc_cfg_t;

	typedef struct packed {
		logic bit_value;
		logic first_bit;
		logic last_bit;
	} rllc_in_t;

	typedef struct packed {
		logic found;
		pos_t result_value;
	} rllc_out_t;

endpackage

// ----- rtl/core/run_length_limit_checker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_limit_checker_core
// Checks a bit stream for runs longer than the configured limits and reports
// the first violating position or the violation count at the end of a scan.
// ----------------------------------------------------------------------------
//  channel   signals                            carries
//  item      item_valid / item_ready / item     one bit with first/last marks
//  result    result_valid / result_ready / res  found flag and value per scan
//  cfg       cfg_we / cfg_index / cfg_wdata     limits, mode, start offset
//
//  one bit per cycle unless a last bit waits behind a held result; a bit is
//  staged in the input register; as it leaves, a last bit's result enters the
//  output register, and the scan state updates in the same cycle a bit leaves
//  the input register; a last bit waits there only while a result is held
//  and result_ready is low; reset clears the configuration and all scan state
// ----------------------------------------------------------------------------
module run_length_limit_checker_core
	import rllc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  rllc_in_t                  item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output rllc_out_t                 result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	rllc_cfg_t cfg;
	rllc_in_t  item_s1;
	logic      valid_s1;
	logic      advance;
	rllc_out_t res_c;
	rllc_out_t res_q;
	logic      res_valid_q;

	rllc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// a staged bit moves on unless it is a last bit and the result slot is full and not being read
	assign advance    = valid_s1 && (!item_s1.last_bit || !res_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	rllc_scan_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.item   (item_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.last_bit) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_bit) begin
			res_q <= res_c;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// a new result in the output register always comes from a last bit
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1 && item_s1.last_bit))
		else $error("result appeared without a last bit");

	// stalling the input only happens behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (valid_s1 && item_s1.last_bit && res_valid_q && !result_ready))
		else $error("input stalled without a pending result");

	// not found in first mode carries a zero value
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |-> (result.result_value == '0))
		else $error("not-found result with non-zero value");

endmodule

// ----- rtl/core/rllc_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module rllc_cfg_regs
	import rllc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
	output rllc_cfg_t                 cfg
);

	rllc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MAX_ZERO_RUN: cfg_q.max_zero_run <= cfg_wdata[RUN_LIMIT_BITS-1:0];
				CFG_MAX_ONE_RUN:  cfg_q.max_one_run  <= cfg_wdata[RUN_LIMIT_BITS-1:0];
				CFG_COUNT_MODE:   cfg_q.count_mode   <= cfg_wdata[0];
				CFG_START_OFFSET: cfg_q.start_offset <= cfg_wdata[POSITION_BITS-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/rllc_scan_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllc_scan_eval
// Per-scan state and combinational evaluation of one bit against the limits.
// ----------------------------------------------------------------------------
module rllc_scan_eval
	import rllc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rllc_cfg_t cfg,
	input  logic      step,
	input  rllc_in_t  item,
	output rllc_out_t res
);

	prev_bit_t prev_q;
	run_t      run_q;
	pos_t      index_q;
	pos_t      count_q;
	logic      ff_q;
	pos_t      fpos_q;

	prev_bit_t prev_c;
	run_t      run_c;
	pos_t      index_c;
	pos_t      count_c;
	logic      ff_c;
	pos_t      fpos_c;

	prev_bit_t prev_n;
	run_t      run_n;
	pos_t      count_n;
	logic      ff_n;
	pos_t      fpos_n;
	pos_t      pos;
	logic      bad;

	always_comb begin
		// a first mark clears the scan history before this bit is counted
		prev_c  = item.first_bit ? PREV_NONE : prev_q;
		run_c   = item.first_bit ? '0 : run_q;
		index_c = item.first_bit ? '0 : index_q;
		count_c = item.first_bit ? '0 : count_q;
		ff_c    = item.first_bit ? 1'b0 : ff_q;
		fpos_c  = item.first_bit ? '0 : fpos_q;

		prev_n = item.bit_value ? PREV_ONE : PREV_ZERO;
		if (prev_c == prev_n) begin
			run_n = (run_c == '1) ? run_c : run_c + run_t'(1);
		end else begin
			run_n = run_t'(1);
		end

		if (item.bit_value) begin
			bad = (cfg.max_one_run != '0) && (run_n > run_t'(cfg.max_one_run));
		end else begin
			bad = (cfg.max_zero_run != '0) && (run_n > run_t'(cfg.max_zero_run));
		end

		pos     = cfg.start_offset + index_c;
		ff_n    = ff_c | bad;
		fpos_n  = (bad && !ff_c) ? pos : fpos_c;
		count_n = (bad && count_c != '1) ? count_c + pos_t'(1) : count_c;

		if (cfg.count_mode) begin
			res.found        = 1'b1;
			res.result_value = count_n;
		end else begin
			res.found        = ff_n;
			res.result_value = ff_n ? fpos_n : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= PREV_NONE;
			run_q   <= '0;
			index_q <= '0;
			count_q <= '0;
			ff_q    <= 1'b0;
			fpos_q  <= '0;
		end else if (step) begin
			if (item.last_bit) begin
				prev_q  <= PREV_NONE;
				run_q   <= '0;
				index_q <= '0;
				count_q <= '0;
				ff_q    <= 1'b0;
				fpos_q  <= '0;
			end else begin
				prev_q  <= prev_n;
				run_q   <= run_n;
				index_q <= index_c + pos_t'(1);
				count_q <= count_n;
				ff_q    <= ff_n;
				fpos_q  <= fpos_n;
			end
		end
	end

endmodule
